// ===== rtl/segmax_pkg.sv =====
// Package with shared widths, codes and reset values of the segment tree range maximum block.
`timescale 1ns / 1ps

package segmax_pkg;

  localparam int unsigned LEAVES_DEFAULT = 1024;

  localparam int unsigned IDX_W  = 10;
  localparam int unsigned VAL_W  = 31;
  localparam int unsigned RES_W  = 32;
  localparam int unsigned SIZE_W = 11;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);
  localparam logic [RES_W-1:0]  EMPTY_VAL  = '1;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

endpackage

// ===== rtl/segmax_req_if.sv =====
// Request channel interface: request type, positions and update value.
`timescale 1ns / 1ps

interface segmax_req_if
  import segmax_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [IDX_W-1:0] index;
  logic [IDX_W-1:0] end_index;
  logic [VAL_W-1:0] value;

  modport source (output valid, output req_type, output index, output end_index,
                  output value, input ready);
  modport sink   (input valid, input req_type, input index, input end_index,
                  input value, output ready);
endinterface

// ===== rtl/segmax_res_if.sv =====
// Result channel interface: the signed range maximum.
`timescale 1ns / 1ps

interface segmax_res_if
  import segmax_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] max_value;

  modport source (output valid, output max_value, input ready);
  modport sink   (input valid, input max_value, output ready);
endinterface

// ===== rtl/segmax_cfg_if.sv =====
// Configuration write channel interface for the size register.
`timescale 1ns / 1ps

interface segmax_cfg_if
  import segmax_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/segmax_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module segmax_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/segment_tree_range_max.sv =====
// Segment tree range maximum: top level with sequencer, size register and result register.
// An update runs from acceptance to the next ready as the leaf write, a sibling read and a
// parent write per level, and a last step at the root. A query runs as the accepting step,
// two single-read steps per level of the bottom-up walk, and the result load, which waits
// while an earlier result is not taken.
// After reset the node memory is cleared to -1 while no request is taken.
`timescale 1ns / 1ps

module segment_tree_range_max
  import segmax_pkg::*;
#(
  parameter int unsigned LEAVES = LEAVES_DEFAULT
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  segmax_req_if.sink   req_i,
  segmax_cfg_if.sink   cfg_i,
  segmax_res_if.source res_o
);
  localparam int unsigned Depth = 2 * LEAVES;
  localparam int unsigned NW    = $clog2(Depth);
  localparam int unsigned RW    = NW + 1;
  localparam int unsigned CW    = ((NW > SIZE_W) ? NW : SIZE_W) + 1;
  localparam logic [NW-1:0] LastAddr = NW'(Depth - 1);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_U_RD = 3'd2;
  localparam logic [2:0] ST_U_WR = 3'd3;
  localparam logic [2:0] ST_Q_L  = 3'd4;
  localparam logic [2:0] ST_Q_R  = 3'd5;

  logic [2:0]              state_q, state_d;
  logic [NW-1:0]           clr_q, clr_d;
  logic [SIZE_W-1:0]       size_q;
  logic [NW-1:0]           p_q, p_d;
  logic [RW-1:0]           l_q, l_d, r_q, r_d;
  logic signed [RES_W-1:0] cur_q, cur_d, best_q, best_d, best_abs, mx;
  logic                    rd_pend_q, rd_pend_d;
  logic                    res_valid_q, res_valid_d;
  logic [RES_W-1:0]        res_data_q, res_data_d;

  logic                    ram_we, ram_re;
  logic [NW-1:0]           ram_waddr, ram_raddr;
  logic [RES_W-1:0]        ram_wdata, ram_rdata;

  logic                    req_acc, upd_ok, qry_ok, out_free;
  logic [CW-1:0]           n_act, s_ext, e_ext, e_clip;
  logic [RW-1:0]           r_dec;

  segmax_ram #(
    .Width(RES_W),
    .Depth(Depth)
  ) u_nodes (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign req_i.ready   = (state_q == ST_IDLE);
  assign cfg_i.ready   = 1'b1;
  assign res_o.valid   = res_valid_q;
  assign res_o.max_value = res_data_q;

  assign req_acc  = req_i.valid && req_i.ready;
  assign out_free = !res_valid_q || res_o.ready;

  assign n_act  = (CW'(size_q) > CW'(LEAVES)) ? CW'(LEAVES) : CW'(size_q);
  assign s_ext  = CW'(req_i.index);
  assign e_ext  = CW'(req_i.end_index);
  assign upd_ok = s_ext < n_act;
  assign qry_ok = (s_ext <= e_ext) && (s_ext < n_act);
  assign e_clip = (e_ext >= n_act) ? (n_act - CW'(1)) : e_ext;

  assign best_abs = (rd_pend_q && ($signed(ram_rdata) > best_q)) ? $signed(ram_rdata) : best_q;
  assign mx       = ($signed(ram_rdata) > cur_q) ? $signed(ram_rdata) : cur_q;
  assign r_dec    = r_q[0] ? (r_q - RW'(1)) : r_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    p_d         = p_q;
    l_d         = l_q;
    r_d         = r_q;
    cur_d       = cur_q;
    best_d      = best_q;
    rd_pend_d   = 1'b0;
    res_valid_d = res_valid_q && !res_o.ready;
    res_data_d  = res_data_q;
    ram_we      = 1'b0;
    ram_waddr   = clr_q;
    ram_wdata   = EMPTY_VAL;
    ram_re      = 1'b0;
    ram_raddr   = p_q ^ NW'(1);

    unique case (state_q)
      ST_CLR: begin
        ram_we = 1'b1;
        clr_d  = clr_q + NW'(1);
        if (clr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_acc) begin
          if (req_i.req_type == REQ_UPDATE) begin
            if (upd_ok) begin
              ram_we    = 1'b1;
              ram_waddr = NW'(LEAVES) + NW'(s_ext);
              ram_wdata = {1'b0, req_i.value};
              p_d       = NW'(LEAVES) + NW'(s_ext);
              cur_d     = $signed({1'b0, req_i.value});
              state_d   = ST_U_RD;
            end
          end else begin
            best_d  = $signed(EMPTY_VAL);
            state_d = ST_Q_L;
            if (qry_ok) begin
              l_d = RW'(LEAVES) + RW'(s_ext);
              r_d = RW'(LEAVES) + RW'(e_clip) + RW'(1);
            end else begin
              l_d = '0;
              r_d = '0;
            end
          end
        end
      end
      ST_U_RD: begin
        if (p_q == NW'(1)) begin
          state_d = ST_IDLE;
        end else begin
          ram_re  = 1'b1;
          state_d = ST_U_WR;
        end
      end
      ST_U_WR: begin
        ram_we    = 1'b1;
        ram_waddr = p_q >> 1;
        ram_wdata = mx;
        cur_d     = mx;
        p_d       = p_q >> 1;
        state_d   = ST_U_RD;
      end
      ST_Q_L: begin
        best_d = best_abs;
        if (!(l_q < r_q)) begin
          if (out_free) begin
            res_valid_d = 1'b1;
            res_data_d  = best_abs;
            state_d     = ST_IDLE;
          end
        end else begin
          if (l_q[0]) begin
            ram_re    = 1'b1;
            ram_raddr = NW'(l_q);
            rd_pend_d = 1'b1;
            l_d       = l_q + RW'(1);
          end
          state_d = ST_Q_R;
        end
      end
      ST_Q_R: begin
        best_d = best_abs;
        if (r_q[0]) begin
          ram_re    = 1'b1;
          ram_raddr = NW'(r_dec);
          rd_pend_d = 1'b1;
        end
        l_d     = l_q >> 1;
        r_d     = r_dec >> 1;
        state_d = ST_Q_L;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      size_q      <= SIZE_RESET;
      rd_pend_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rd_pend_q   <= rd_pend_d;
      res_valid_q <= res_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        size_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    l_q        <= l_d;
    r_q        <= r_d;
    cur_q      <= cur_d;
    best_q     <= best_d;
    res_data_q <= res_data_d;
  end

  a_no_result_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> !res_valid_q)
    else $error("Result offered during the memory clearing pass.");

  a_write_sources: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLR || state_q == ST_IDLE || state_q == ST_U_WR))
    else $error("Node memory written outside clearing, leaf write or parent update.");

  a_update_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && req_i.req_type == REQ_UPDATE && !upd_ok) |=> (state_q == ST_IDLE))
    else $error("Out-of-range update did not return straight to idle.");

  a_read_pending_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> ($past(state_q) == ST_Q_L || $past(state_q) == ST_Q_R))
    else $error("Pending query read without a query step issuing it.");

  a_range_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_L || state_q == ST_Q_R) |-> (l_q <= r_q))
    else $error("Query walk bounds crossed.");
endmodule
